### src/wwsf_pkg.sv
// ----------------------------------------------------------------------------
// wwsf_pkg
// Shared types and constants of the weighted window sum filter.
// ----------------------------------------------------------------------------
package wwsf_pkg;

    localparam int MAX_COLS  = 1024;
    localparam int MAX_HALF  = 3;
    localparam int LINES     = 2 * MAX_HALF + 1;
    localparam int CELLS     = 2 * MAX_HALF + 1;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int BANK_W    = $clog2(LINES);
    localparam int ROW_W     = 16;
    localparam int COLS_W    = 11;
    localparam int HALF_W    = 2;
    localparam int PIX_W     = 8;
    localparam int COLSUM_W  = $clog2(LINES * 255 + 1);
    localparam int SUM_W     = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_ROWS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_COLS  = 2'd3;

    typedef struct packed {
        logic [7:0]  pixel;
        logic [16:0] weight;
    } s_req_t;

    typedef struct packed {
        logic [SUM_W-1:0] window_sum;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             last;
    } m_req_t;

    // column sums of one column, one per output row offset
    typedef logic [MAX_HALF:0][COLSUM_W-1:0] colsum_t;

    typedef logic [LINES-1:0][PIX_W-1:0] line_taps_t;

endpackage

### src/wwsf_line_store.sv
// ----------------------------------------------------------------------------
// wwsf_line_store
// Product line store: one bank per line, one write and one read per bank.
// ----------------------------------------------------------------------------
module wwsf_line_store
    import wwsf_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [BANK_W-1:0] wr_bank,
    input  logic [COL_W-1:0]  wr_addr,
    input  logic [PIX_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [COL_W-1:0]  rd_addr,
    output line_taps_t        rd_data
);

    for (genvar b = 0; b < LINES; b++) begin : g_bank
        logic [PIX_W-1:0] mem [MAX_COLS];

        always_ff @(posedge aclk) begin
            if (wr_en && (wr_bank == BANK_W'(b))) begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en) begin
                rd_data[b] <= mem[rd_addr];
            end
        end
    end

endmodule

### src/wwsf_col_cell.sv
// ----------------------------------------------------------------------------
// wwsf_col_cell
// One cell of the column sum chain: holds the sums of one column.
// ----------------------------------------------------------------------------
module wwsf_col_cell
    import wwsf_pkg::*;
(
    input  logic    aclk,
    input  logic    shift_en,
    input  colsum_t d_in,
    output colsum_t q_reg
);

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            q_reg <= d_in;
        end
    end

endmodule

### src/weighted_window_sum_filter_core.sv
// Throughput: one request per cycle while no request has results pending; a
// request of n windows holds the input until all n are out, one result per
// cycle while m_ready is high, set by the single summing stage. Line store
// banks take one write and one read per cycle. Reset sets the configuration
// to one and clears valid flags and frame counters; line store contents stay
// undefined and are never used before being written in the same frame.
// ----------------------------------------------------------------------------
// weighted_window_sum_filter_core
// Weighted pixel window sum with replicate border over a chain of column cells.
// ----------------------------------------------------------------------------
module weighted_window_sum_filter_core
    import wwsf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  s_req_t               s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output m_req_t               m_data
);

    logic [ROW_W-1:0]  image_rows_reg;
    logic [COLS_W-1:0] image_cols_reg;
    logic [HALF_W-1:0] half_rows_reg;
    logic [HALF_W-1:0] half_cols_reg;

    logic [ROW_W-1:0]  row_count_reg;
    logic [COL_W-1:0]  col_count_reg;
    logic [BANK_W-1:0] bank_reg;

    logic [ROW_W-1:0]  nr_eff;
    logic [COLS_W-1:0] nc_eff;
    logic              in_row_last;
    logic              in_col_last;
    logic [24:0]       prod_full;
    logic [PIX_W-1:0]  prod_sat;
    logic              accept;

    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_prod_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [BANK_W-1:0] s1_bank_reg;
    logic              s1_row_last_reg;
    logic              s1_col_last_reg;
    line_taps_t        line_rd;
    line_taps_t        tap;
    colsum_t           new_cs;
    colsum_t           cell_q [CELLS];

    logic              s2_valid_reg;
    logic [ROW_W-1:0]  s2_row_reg;
    logic [COL_W-1:0]  s2_col_reg;
    logic              s2_row_last_reg;
    logic              s2_col_last_reg;
    logic              s2_have_reg;
    logic [HALF_W-1:0] i_reg;
    logic [HALF_W-1:0] j_reg;
    logic [HALF_W-1:0] j_hi_reg;

    logic              adv2;
    logic              emit;
    logic              i_end;
    logic              j_end;
    logic              res_last;
    logic              s2_done;
    logic [SUM_W-1:0]  sum_next;
    logic              have_next;
    logic [HALF_W-1:0] i_start;
    logic [HALF_W-1:0] j_start;

    logic              m_valid_reg;
    m_req_t            m_data_reg;

    // ---------------- input stage ----------------
    assign nr_eff = (image_rows_reg == '0) ? ROW_W'(1) : image_rows_reg;
    assign nc_eff = (image_cols_reg == '0) ? COLS_W'(1) :
                    (image_cols_reg > COLS_W'(MAX_COLS)) ? COLS_W'(MAX_COLS) : image_cols_reg;
    assign in_row_last = (row_count_reg == nr_eff - ROW_W'(1));
    assign in_col_last = ({1'b0, col_count_reg} == nc_eff - COLS_W'(1));
    assign prod_full   = 25'(s_data.pixel) * 25'(s_data.weight);
    assign prod_sat    = (prod_full[24] == 1'b1) ? 8'hFF : prod_full[23:16];
    assign accept      = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_rows_reg <= ROW_W'(1);
            image_cols_reg <= COLS_W'(1);
            half_rows_reg  <= HALF_W'(1);
            half_cols_reg  <= HALF_W'(1);
            row_count_reg  <= '0;
            col_count_reg  <= '0;
            bank_reg       <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_IMAGE_ROWS: image_rows_reg <= cfg_data;
                REG_IMAGE_COLS: image_cols_reg <= cfg_data[COLS_W-1:0];
                REG_HALF_ROWS:  half_rows_reg  <= cfg_data[HALF_W-1:0];
                REG_HALF_COLS:  half_cols_reg  <= cfg_data[HALF_W-1:0];
            endcase
            // restart the frame
            row_count_reg <= '0;
            col_count_reg <= '0;
            bank_reg      <= '0;
        end else if (accept) begin
            if (in_col_last) begin
                col_count_reg <= '0;
                if (in_row_last) begin
                    row_count_reg <= '0;
                    bank_reg      <= '0;
                end else begin
                    row_count_reg <= row_count_reg + ROW_W'(1);
                    bank_reg      <= (bank_reg == BANK_W'(LINES - 1)) ? '0
                                                                      : bank_reg + BANK_W'(1);
                end
            end else begin
                col_count_reg <= col_count_reg + COL_W'(1);
            end
        end
    end

    wwsf_line_store u_line_store (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_bank (bank_reg),
        .wr_addr (col_count_reg),
        .wr_data (prod_sat),
        .rd_en   (accept),
        .rd_addr (col_count_reg),
        .rd_data (line_rd)
    );

    // ---------------- column sum stage ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (adv2) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_prod_reg     <= prod_sat;
            s1_row_reg      <= row_count_reg;
            s1_col_reg      <= col_count_reg;
            s1_bank_reg     <= bank_reg;
            s1_row_last_reg <= in_row_last;
            s1_col_last_reg <= in_col_last;
        end
    end

    // tap t holds the product of row (current row - t) at this column
    always_comb begin : colsum_calc
        int bk;
        int x;
        logic [COLSUM_W-1:0] acc;
        bk  = 0;
        x   = 0;
        acc = '0;
        tap[0] = s1_prod_reg;
        for (int t = 1; t < LINES; t++) begin
            bk = int'(s1_bank_reg) - t;
            if (bk < 0) begin
                bk = bk + LINES;
            end
            tap[t] = line_rd[bk[BANK_W-1:0]];
        end
        for (int i = 0; i <= MAX_HALF; i++) begin
            acc = '0;
            for (int dr = -MAX_HALF; dr <= MAX_HALF; dr++) begin
                if ((dr <= int'(half_rows_reg)) && (-dr <= int'(half_rows_reg))) begin
                    x = i - dr;
                    if (x < 0) begin
                        x = 0;
                    end
                    if (x > int'(s1_row_reg)) begin
                        x = int'(s1_row_reg);
                    end
                    acc = acc + COLSUM_W'(tap[x[BANK_W-1:0]]);
                end
            end
            new_cs[i] = acc;
        end
    end

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        if (k == 0) begin : g_head
            wwsf_col_cell u_cell (
                .aclk     (aclk),
                .shift_en (adv2),
                .d_in     (new_cs),
                .q_reg    (cell_q[k])
            );
        end else begin : g_body
            wwsf_col_cell u_cell (
                .aclk     (aclk),
                .shift_en (adv2),
                .d_in     (cell_q[k-1]),
                .q_reg    (cell_q[k])
            );
        end
    end

    // ---------------- window sum and result sequencing ----------------
    assign have_next = (s1_row_last_reg || (s1_row_reg >= ROW_W'(half_rows_reg))) &&
                       (s1_col_last_reg || (s1_col_reg >= COL_W'(half_cols_reg)));
    assign i_start   = (s1_row_last_reg && (s1_row_reg < ROW_W'(half_rows_reg)))
                       ? s1_row_reg[HALF_W-1:0] : half_rows_reg;
    assign j_start   = (s1_col_last_reg && (s1_col_reg < COL_W'(half_cols_reg)))
                       ? s1_col_reg[HALF_W-1:0] : half_cols_reg;

    assign i_end    = !s2_row_last_reg || (i_reg == '0);
    assign j_end    = !s2_col_last_reg || (j_reg == '0);
    assign res_last = i_end && j_end;
    assign emit     = s2_valid_reg && s2_have_reg && (!m_valid_reg || m_ready);
    assign s2_done  = s2_valid_reg && (!s2_have_reg || (emit && res_last));
    assign adv2     = s1_valid_reg && (!s2_valid_reg || s2_done);
    assign s_ready  = !s1_valid_reg || adv2;

    // cell k holds column (current column - k); clamp at both frame edges
    always_comb begin : window_calc
        int kk;
        kk = 0;
        sum_next = '0;
        for (int d = -MAX_HALF; d <= MAX_HALF; d++) begin
            if ((d <= int'(half_cols_reg)) && (-d <= int'(half_cols_reg))) begin
                kk = int'(j_reg) - d;
                if (kk < 0) begin
                    kk = 0;
                end
                if (kk > int'(s2_col_reg)) begin
                    kk = int'(s2_col_reg);
                end
                sum_next = sum_next + SUM_W'(cell_q[kk[BANK_W-1:0]][i_reg]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv2) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_done) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            s2_row_reg      <= s1_row_reg;
            s2_col_reg      <= s1_col_reg;
            s2_row_last_reg <= s1_row_last_reg;
            s2_col_last_reg <= s1_col_last_reg;
            s2_have_reg     <= have_next;
            i_reg           <= i_start;
            j_reg           <= j_start;
            j_hi_reg        <= j_start;
        end else if (emit && !res_last) begin
            if (j_end) begin
                j_reg <= j_hi_reg;
                i_reg <= i_reg - HALF_W'(1);
            end else begin
                j_reg <= j_reg - HALF_W'(1);
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg.window_sum <= sum_next;
            m_data_reg.out_row    <= s2_row_reg - ROW_W'(i_reg);
            m_data_reg.out_col    <= s2_col_reg - COL_W'(j_reg);
            m_data_reg.last       <= res_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- assertions ----------------
    a_one_row_mid_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && !s2_row_last_reg |-> i_reg == half_rows_reg)
        else $error("result row offset differs from half height away from frame end");

    a_col_offset_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && s2_have_reg |-> j_reg <= j_hi_reg)
        else $error("column offset beyond its start value");

    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> sum_next <= SUM_W'(12495))
        else $error("window sum out of range");

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> (row_count_reg == '0) && (col_count_reg == '0) && (bank_reg == '0))
        else $error("frame position not restarted after register write");

endmodule
